// File: src/uer_pkg.sv
package uer_pkg;

    // largest legal code point
    localparam logic [31:0] MAX_CODE = 32'h0010_FFFF;

    localparam logic [3:0] LONG_DIGITS  = 4'd8;
    localparam logic [3:0] SHORT_DIGITS = 4'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_DIGITS
    } t_mode;

    // what comes ahead of the optional tail byte
    typedef enum logic [2:0] {
        PRE_NONE,   // nothing
        PRE_SLASH,  // a lone held backslash
        PRE_HELD,   // backslash, u/U, held digits (broken escape)
        PRE_ESC,    // backslash x { digits }
        PRE_ERR     // single error beat
    } t_pre;

    typedef struct packed {
        t_pre            pre;
        logic            upper;       // letter of a held escape is 'U'
        logic [7:0][7:0] digits;
        logic [3:0]      n_dig;
        logic            tail_valid;
        logic [7:0]      tail;
        logic            last;        // mark final beat with out_last
        logic [3:0]      len;         // beats in this command, 1..12
    } t_cmd;

endpackage

// File: src/uer_in_if.sv
interface uer_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: src/uer_out_if.sv
interface uer_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_byte, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_error,
                    output ready);
endinterface

// File: src/unicode_escape_rewriter_core.sv
// Streams pattern text and rewrites each \uXXXX and \UXXXXXXXX escape as
// \x{digits}, digits kept as written; a broken candidate passes through unchanged
// and a complete escape above 0x10FFFF gives one error beat (byte 0, error and last
// set) after which the pattern is skipped up to its in_last byte. The front end
// takes one input beat per cycle whenever its four-entry command queue has room,
// with no path from the output ready back to the input ready. The back end sends
// one result beat per cycle while the output is ready; an input byte produces 0
// to 12 result beats (12 for a complete long escape). The output beat rate of the
// back end sets the sustained rate, and the queue soaks up bursts. With the back
// end idle, the command of an accepted byte passes the queue and then the
// registered output stage before its first result beat is offered.
module unicode_escape_rewriter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_in_if.sink    i_in,
    uer_out_if.source o_out
);

    // front end -> queue
    logic          w_push;
    uer_pkg::t_cmd w_push_cmd;
    logic          w_full;

    // queue -> back end
    logic          w_qvalid;
    uer_pkg::t_cmd w_head_cmd;
    logic          w_pop;

    // scan state machine: classifies each byte and pushes one command per
    // byte that produces output
    uer_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    uer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_cmd   (w_head_cmd)
    );

    // expands a command into beats through a registered output stage
    uer_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("command pushed into full queue");

    // pop only a valid head
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("command popped from empty queue");

    // error beat is always final and carries a zero byte
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_error) |-> (o_out.out_last && (o_out.out_byte == 8'h00)))
        else $error("malformed error beat");

    // a pop with no push in the same cycle leaves the queue not full
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> !w_full)
        else $error("queue still full after pop");

endmodule

// File: src/uer_front.sv
module uer_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uer_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output uer_pkg::t_cmd o_cmd
);

    function automatic logic hex_ok(input logic [7:0] b);
        hex_ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
              || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_of(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h57;
        end else begin
            v = b - 8'h37;
        end
        hex_of = v[3:0];
    endfunction

    uer_pkg::t_mode  r_mode, n_mode;
    logic            r_long, n_long;
    logic [3:0]      r_count, n_count;
    logic [31:0]     r_code, n_code;
    logic            r_dropping, n_dropping;
    logic [7:0][7:0] r_held;
    logic [7:0][7:0] w_held_nx;

    logic [7:0]  b;
    logic        last, acc, live;
    logic        is_bs, is_u, is_hex;
    logic [3:0]  cnt1, need;
    logic [31:0] code1;
    logic        done, over;
    logic        in_slash, in_digits;
    logic        flush_slash, flush_held, rescan, digit, err, esc, open, partial;
    logic        tail_byte, new_slash;

    assign b    = i_in.in_byte;
    assign last = i_in.in_last;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign live       = acc && !r_dropping;

    assign is_bs  = (b == uer_pkg::CH_BSLASH);
    assign is_u   = (b == uer_pkg::CH_LOW_U) || (b == uer_pkg::CH_UP_U);
    assign is_hex = hex_ok(b);

    assign cnt1  = r_count + 4'd1;
    assign need  = r_long ? uer_pkg::LONG_DIGITS : uer_pkg::SHORT_DIGITS;
    assign code1 = {r_code[27:0], hex_of(b)};
    assign done  = (cnt1 >= need);
    assign over  = (code1 > uer_pkg::MAX_CODE);

    assign in_slash  = (r_mode == uer_pkg::MODE_SLASH);
    assign in_digits = (r_mode == uer_pkg::MODE_DIGITS);

    // event decode of the accepted byte
    assign flush_slash = live && in_slash && !is_u;
    assign flush_held  = live && in_digits && !is_hex;
    assign rescan      = (live && !in_slash && !in_digits) || flush_slash || flush_held;
    assign open        = live && in_slash && is_u;
    assign digit       = live && in_digits && is_hex;
    assign err         = digit && done && over;
    assign esc         = digit && done && !over;
    assign partial     = digit && !done;
    assign tail_byte   = rescan && !is_bs;
    assign new_slash   = rescan && is_bs;

    always_comb begin
        w_held_nx = r_held;
        if (digit) begin
            w_held_nx[r_count[2:0]] = b;
        end
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_long     = r_long;
        n_count    = r_count;
        n_code     = r_code;
        n_dropping = r_dropping;
        if (acc && r_dropping) begin
            if (last) begin
                n_dropping = 1'b0;
            end
        end else if (live) begin
            priority if (err) begin
                n_mode     = uer_pkg::MODE_IDLE;
                n_count    = '0;
                n_code     = '0;
                n_dropping = !last;
            end else if (last) begin
                n_mode  = uer_pkg::MODE_IDLE;
                n_count = '0;
                n_code  = '0;
                n_long  = 1'b0;
            end else if (open) begin
                n_mode  = uer_pkg::MODE_DIGITS;
                n_long  = (b == uer_pkg::CH_UP_U);
                n_count = '0;
                n_code  = '0;
            end else if (partial) begin
                n_count = cnt1;
                n_code  = code1;
            end else if (new_slash) begin
                n_mode  = uer_pkg::MODE_SLASH;
                n_count = '0;
                n_code  = '0;
            end else begin
                n_mode  = uer_pkg::MODE_IDLE;
                n_count = '0;
                n_code  = '0;
            end
        end
    end

    // command to the back end
    always_comb begin
        o_cmd            = '0;
        o_cmd.pre        = uer_pkg::PRE_NONE;
        o_cmd.digits     = w_held_nx;
        o_cmd.upper      = open ? (b == uer_pkg::CH_UP_U) : r_long;
        o_cmd.last       = err || last;
        priority if (err) begin
            o_cmd.pre = uer_pkg::PRE_ERR;
        end else if (esc) begin
            o_cmd.pre   = uer_pkg::PRE_ESC;
            o_cmd.n_dig = need;
        end else if (flush_slash) begin
            o_cmd.pre = uer_pkg::PRE_SLASH;
        end else if (flush_held) begin
            o_cmd.pre   = uer_pkg::PRE_HELD;
            o_cmd.n_dig = r_count;
        end else if (last && (open || partial)) begin
            // pattern ends inside an escape
            o_cmd.pre   = uer_pkg::PRE_HELD;
            o_cmd.n_dig = open ? 4'd0 : cnt1;
        end else begin
            o_cmd.pre = uer_pkg::PRE_NONE;
        end
        if (tail_byte) begin
            o_cmd.tail_valid = 1'b1;
            o_cmd.tail       = b;
        end else if (new_slash && last) begin
            o_cmd.tail_valid = 1'b1;
            o_cmd.tail       = uer_pkg::CH_BSLASH;
        end
        unique case (o_cmd.pre)
            uer_pkg::PRE_SLASH: o_cmd.len = 4'd1;
            uer_pkg::PRE_HELD:  o_cmd.len = 4'd2 + o_cmd.n_dig;
            uer_pkg::PRE_ESC:   o_cmd.len = 4'd4 + o_cmd.n_dig;
            uer_pkg::PRE_ERR:   o_cmd.len = 4'd1;
            default:            o_cmd.len = 4'd0;
        endcase
        o_cmd.len = o_cmd.len + {3'd0, o_cmd.tail_valid};
        o_push    = live && ((o_cmd.pre != uer_pkg::PRE_NONE) || o_cmd.tail_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= uer_pkg::MODE_IDLE;
            r_long     <= 1'b0;
            r_count    <= '0;
            r_code     <= '0;
            r_dropping <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_long     <= n_long;
            r_count    <= n_count;
            r_code     <= n_code;
            r_dropping <= n_dropping;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= w_held_nx;
    end

endmodule

// File: src/uer_queue.sv
module uer_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uer_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output uer_pkg::t_cmd o_cmd
);

    uer_pkg::t_cmd                r_mem [uer_pkg::QUEUE_DEPTH];
    logic [uer_pkg::QPTR_W-1:0]   r_wp, n_wp;
    logic [uer_pkg::QPTR_W-1:0]   r_rp, n_rp;
    logic [uer_pkg::QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == uer_pkg::QCNT_W'(uer_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: src/uer_back.sv
module uer_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  uer_pkg::t_cmd i_cmd,
    output logic          o_pop,
    uer_out_if.source     o_out
);

    function automatic logic [7:0] beat_byte(input uer_pkg::t_cmd c, input logic [3:0] pos);
        logic [3:0] k2;
        logic [3:0] k3;
        logic [7:0] v;
        k2 = pos - 4'd2;
        k3 = pos - 4'd3;
        v  = 8'h00;
        if (c.tail_valid && (pos == c.len - 4'd1)) begin
            v = c.tail;
        end else begin
            unique case (c.pre)
                uer_pkg::PRE_SLASH: v = uer_pkg::CH_BSLASH;
                uer_pkg::PRE_HELD: begin
                    priority if (pos == 4'd0) begin
                        v = uer_pkg::CH_BSLASH;
                    end else if (pos == 4'd1) begin
                        v = c.upper ? uer_pkg::CH_UP_U : uer_pkg::CH_LOW_U;
                    end else begin
                        v = c.digits[k2[2:0]];
                    end
                end
                uer_pkg::PRE_ESC: begin
                    priority if (pos == 4'd0) begin
                        v = uer_pkg::CH_BSLASH;
                    end else if (pos == 4'd1) begin
                        v = uer_pkg::CH_X;
                    end else if (pos == 4'd2) begin
                        v = uer_pkg::CH_LBRACE;
                    end else if (pos == c.len - 4'd1) begin
                        v = uer_pkg::CH_RBRACE;
                    end else begin
                        v = c.digits[k3[2:0]];
                    end
                end
                default: v = 8'h00;
            endcase
        end
        beat_byte = v;
    endfunction

    logic [3:0] r_pos, n_pos;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_error;
    logic       load, is_end;

    assign load   = i_valid && (!r_valid || o_out.ready);
    assign is_end = (r_pos == i_cmd.len - 4'd1);
    assign o_pop  = load && is_end;

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        if (r_valid && o_out.ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_pos   = is_end ? 4'd0 : r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= beat_byte(i_cmd, r_pos);
            r_last  <= i_cmd.last && is_end;
            r_error <= (i_cmd.pre == uer_pkg::PRE_ERR);
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.out_last  = r_last;
    assign o_out.out_error = r_error;

endmodule

// File: bench/unicode_escape_rewriter_core_tb.sv
module unicode_escape_rewriter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_rewrite_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uer_in_if  in_ch ();
    uer_out_if out_ch ();

    unicode_escape_rewriter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // text waiting to be sent, and rewritten beats still owed by the block
    t_text_beat    text_q[$];
    t_rewrite_beat rewritten_q[$];
    t_rewrite_beat step_beats[$];

    int  text_total;
    int  text_sent;
    int  fail_count;
    logic calm;

    // mid-run window where neither side holds off
    assign calm = (text_sent >= 150) && (text_sent < 300);

    // ---------------------------------------------------------------
    // escape scanner mirror
    // ---------------------------------------------------------------
    uer_pkg::t_mode esc_mode;
    logic           esc_long;
    logic [7:0]     esc_digits [8];
    logic [3:0]     esc_cnt;
    logic [31:0]    esc_code;
    logic           skip_rest;

    function automatic logic is_hex(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] b);
        if (b >= "0" && b <= "9") return 4'(b - "0");
        if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
        return 4'(b - "A" + 10);
    endfunction

    function automatic void owe(logic [7:0] b, logic err);
        t_rewrite_beat r;
        r.data = b;
        r.last = 1'b0;
        r.err  = err;
        step_beats.push_back(r);
    endfunction

    // release whatever candidate escape is held, unchanged
    function automatic void release_held();
        if (esc_mode == uer_pkg::MODE_SLASH) begin
            owe(uer_pkg::CH_BSLASH, 1'b0);
        end else if (esc_mode == uer_pkg::MODE_DIGITS) begin
            owe(uer_pkg::CH_BSLASH, 1'b0);
            owe(esc_long ? uer_pkg::CH_UP_U : uer_pkg::CH_LOW_U, 1'b0);
            for (int i = 0; i < esc_cnt && i < 8; i++) owe(esc_digits[i], 1'b0);
        end
        esc_mode = uer_pkg::MODE_IDLE;
        esc_cnt  = '0;
        esc_code = '0;
    endfunction

    function automatic void scan_plain(logic [7:0] b);
        if (b == uer_pkg::CH_BSLASH) esc_mode = uer_pkg::MODE_SLASH;
        else owe(b, 1'b0);
    endfunction

    // one byte through the scanner; 1 when it closed an out-of-range escape
    function automatic logic scan_byte(logic [7:0] b);
        logic [3:0] need;
        if (esc_mode == uer_pkg::MODE_SLASH) begin
            if (b == uer_pkg::CH_LOW_U || b == uer_pkg::CH_UP_U) begin
                esc_mode = uer_pkg::MODE_DIGITS;
                esc_long = (b == uer_pkg::CH_UP_U);
                esc_cnt  = '0;
                esc_code = '0;
            end else begin
                release_held();
                scan_plain(b);
            end
            return 1'b0;
        end
        if (esc_mode == uer_pkg::MODE_DIGITS) begin
            if (!is_hex(b)) begin
                release_held();
                scan_plain(b);
                return 1'b0;
            end
            need = esc_long ? uer_pkg::LONG_DIGITS : uer_pkg::SHORT_DIGITS;
            esc_digits[esc_cnt[2:0]] = b;
            esc_cnt  = esc_cnt + 4'd1;
            esc_code = {esc_code[27:0], hex_val(b)};
            if (esc_cnt >= need) begin
                if (esc_code > uer_pkg::MAX_CODE) begin
                    owe(8'h00, 1'b1);
                    esc_mode = uer_pkg::MODE_IDLE;
                    esc_cnt  = '0;
                    esc_code = '0;
                    return 1'b1;
                end
                owe(uer_pkg::CH_BSLASH, 1'b0);
                owe(uer_pkg::CH_X, 1'b0);
                owe(uer_pkg::CH_LBRACE, 1'b0);
                for (int i = 0; i < need; i++) owe(esc_digits[i], 1'b0);
                owe(uer_pkg::CH_RBRACE, 1'b0);
                esc_mode = uer_pkg::MODE_IDLE;
                esc_cnt  = '0;
                esc_code = '0;
            end
            return 1'b0;
        end
        esc_mode = uer_pkg::MODE_IDLE;
        scan_plain(b);
        return 1'b0;
    endfunction

    // work out the rewritten beats owed for one accepted text beat
    function automatic void rewrite_byte(logic [7:0] b, logic last);
        step_beats.delete();
        if (skip_rest) begin
            if (last) skip_rest = 1'b0;
            return;
        end
        if (scan_byte(b)) begin
            step_beats[0].last = 1'b1;
            if (!last) skip_rest = 1'b1;
        end else if (last) begin
            release_held();
            esc_long = 1'b0;
            if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
        end
        foreach (step_beats[i]) rewritten_q.push_back(step_beats[i]);
    endfunction

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------
    function automatic void send_text(string s, logic end_last);
        t_text_beat t;
        for (int i = 0; i < s.len(); i++) begin
            t.data = s[i];
            t.last = end_last && (i == s.len() - 1);
            text_q.push_back(t);
        end
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_hex(b)) b = 8'($urandom_range(255));
        return b;
    endfunction

    // a pattern of random segments: plain bytes, escapes (some out of range), broken candidates
    function automatic void send_pattern();
        logic [7:0]  pat[$];
        logic [31:0] val;
        int          segs;
        int          kind;
        int          need;
        int          k;
        t_text_beat  t;
        segs = $urandom_range(1, 6);
        for (int s = 0; s < segs; s++) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) pat.push_back(8'($urandom_range(255)));
            end else if (kind < 78) begin
                if (kind < 50) begin
                    need = 4;
                    val  = $urandom_range(16'hFFFF);
                end else if (kind < 72) begin
                    need = 8;
                    case ($urandom_range(3))
                        0:       val = $urandom_range(255);
                        1:       val = 32'h0010_FFFF;
                        default: val = $urandom_range(32'h0010_FFFF);
                    endcase
                end else begin
                    // out of range: aborts the rest of the pattern
                    need = 8;
                    val  = $urandom_range(1) ? 32'h0011_0000
                                             : $urandom_range(32'hFFFF_FFFF, 32'h0011_0000);
                end
                pat.push_back(uer_pkg::CH_BSLASH);
                pat.push_back(need == 8 ? uer_pkg::CH_UP_U : uer_pkg::CH_LOW_U);
                for (int i = need - 1; i >= 0; i--) pat.push_back(hex_char(val[4*i +: 4]));
            end else begin
                // broken or cut-short candidate
                need = $urandom_range(1) ? 8 : 4;
                pat.push_back(uer_pkg::CH_BSLASH);
                if ($urandom_range(4) != 0) begin
                    pat.push_back(need == 8 ? uer_pkg::CH_UP_U : uer_pkg::CH_LOW_U);
                    k = $urandom_range(need - 1);
                    for (int i = 0; i < k; i++) pat.push_back(hex_char(4'($urandom_range(15))));
                end
                if (kind < 92) pat.push_back(non_hex());
            end
        end
        foreach (pat[i]) begin
            t.data = pat[i];
            t.last = (i == pat.size() - 1);
            text_q.push_back(t);
        end
    endfunction

    // ---------------------------------------------------------------
    // driver: text beats from the queue, random gaps
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_text
        t_text_beat nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                rewrite_byte(in_ch.in_byte, in_ch.in_last);
                text_sent <= text_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (text_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
                    nxt = text_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= nxt.data;
                    in_ch.in_last <= nxt.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: compare each result beat with the oldest one owed
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_rewrite
        t_rewrite_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (rewritten_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected beat: byte %02h last %0b err %0b",
                                 out_ch.out_byte, out_ch.out_last, out_ch.out_error);
                    fail_count <= fail_count + 1;
                end else begin
                    want = rewritten_q.pop_front();
                    if (out_ch.out_byte !== want.data || out_ch.out_last !== want.last ||
                        out_ch.out_error !== want.err) begin
                        if (fail_count < 10)
                            $display(
                                "mismatch: expected %02h last %0b err %0b, got %02h %0b %0b",
                                want.data, want.last, want.err,
                                out_ch.out_byte, out_ch.out_last, out_ch.out_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        text_sent     = 0;
        fail_count    = 0;
        esc_mode      = uer_pkg::MODE_IDLE;
        esc_long      = 1'b0;
        esc_cnt       = '0;
        esc_code      = '0;
        skip_rest     = 1'b0;
        foreach (esc_digits[i]) esc_digits[i] = 8'h00;

        // byte extremes
        text_q.push_back('{data: 8'h00, last: 1'b0});
        text_q.push_back('{data: 8'hFF, last: 1'b1});
        // doubled backslash ahead of a good short escape, mixed case digits
        send_text("\\\\uAf90", 1'b1);
        // long escape just past the top code point, tail skipped
        send_text("\\U00110000}", 1'b1);
        // non-hex byte breaks the escape
        send_text("\\u7G", 1'b1);
        // pattern ends inside an escape
        send_text("\\UF", 1'b1);

        while (text_q.size() < 450) send_pattern();
        text_total = text_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(text_sent == text_total && rewritten_q.size() == 0)) @(posedge i_clk);
        // let any stray beats show up
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
src/uer_pkg.sv
src/uer_in_if.sv
src/uer_out_if.sv
src/uer_front.sv
src/uer_queue.sv
src/uer_back.sv
src/unicode_escape_rewriter_core.sv
bench/unicode_escape_rewriter_core_tb.sv
